[rtl/assert_macros.svh]
// Assertion macros for the placer RTL.
// Needs nothing else; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under an active-low reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under an active-low reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ncp_pkg.sv]
// Package for the circle placer: field widths, register indexes, state codes
// and the structs passed between front end, queue and checker. No dependencies.
package ncp_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned RADIUS_W  = 30;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned Q_DEPTH   = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CIRCLE_COUNT = 3'd0,
    REG_RADIUS       = 3'd1,
    REG_WEST_EDGE    = 3'd2,
    REG_EAST_EDGE    = 3'd3,
    REG_SOUTH_EDGE   = 3'd4,
    REG_NORTH_EDGE   = 3'd5
  } ncp_reg_e;

  typedef enum logic {
    ACT_RESTART = 1'b0,
    ACT_OFFER   = 1'b1
  } ncp_action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_SCAN,
    ST_FINISH
  } ncp_back_state_e;

  typedef struct packed {
    logic [COUNT_W-1:0]         circle_count;
    logic [RADIUS_W-1:0]        radius;
    logic signed [COORD_W-1:0]  west_edge;
    logic signed [COORD_W-1:0]  east_edge;
    logic signed [COORD_W-1:0]  south_edge;
    logic signed [COORD_W-1:0]  north_edge;
  } ncp_cfg_t;

  typedef struct packed {
    ncp_action_e                action;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
  } ncp_item_t;

  typedef struct packed {
    logic                       accepted;
    logic signed [COORD_W-1:0]  center_x;
    logic signed [COORD_W-1:0]  center_y;
    logic [SLOT_W-1:0]          slot;
    logic                       complete;
    logic                       struggling;
    logic                       gave_up;
  } ncp_result_t;

endpackage

[rtl/ncp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ncp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ncp_front.sv]
// Front end: takes input beats and scales the Q0.16 fractions into the
// shrunk window over four pipeline stages. Depends on ncp_pkg.
module ncp_front import ncp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ncp_cfg_t          cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              action_i,
  input  logic [FRAC_W-1:0] frac_x_i,
  input  logic [FRAC_W-1:0] frac_y_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output ncp_item_t         push_item_o
);

  localparam int unsigned LO_W   = COORD_W + 2;
  localparam int unsigned SPAN_W = COORD_W + 3;
  localparam int unsigned PROD_W = SPAN_W + FRAC_W + 1;
  localparam int unsigned Q_W    = PROD_W - FRAC_W;
  localparam int unsigned SUM_W  = Q_W + 1;

  logic en;
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;

  ncp_action_e              act1_q, act2_q, act3_q;
  logic [FRAC_W-1:0]        fx1_q, fy1_q, fx2_q, fy2_q;
  logic signed [LO_W-1:0]   lox1_q, hix1_q, loy1_q, hiy1_q;
  logic signed [LO_W-1:0]   lox2_q, loy2_q, lox3_q, loy3_q;
  logic signed [SPAN_W-1:0] spx2_q, spy2_q;
  logic signed [PROD_W-1:0] prx3_q, pry3_q;
  ncp_item_t                item_q;

  logic signed [LO_W-1:0]   lox_d, hix_d, loy_d, hiy_d;
  logic signed [SPAN_W-1:0] spx_d, spy_d;
  logic signed [PROD_W-1:0] prx_d, pry_d;
  logic signed [SUM_W-1:0]  sumx, sumy;

  function automatic logic signed [LO_W-1:0] add_r(input logic signed [COORD_W-1:0] bound,
                                                   input logic [RADIUS_W-1:0] r,
                                                   input logic sub);
    logic signed [LO_W-1:0] b;
    logic signed [LO_W-1:0] rr;
    b  = {{2{bound[COORD_W-1]}}, bound};
    rr = {{(LO_W-RADIUS_W){1'b0}}, r};
    return sub ? (b - rr) : (b + rr);
  endfunction

  function automatic logic signed [COORD_W-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-COORD_W:0] top;
    top = v[SUM_W-1:COORD_W-1];
    if ((&top) || !(|top)) begin
      return v[COORD_W-1:0];
    end
    return v[SUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
  endfunction

  assign en         = !s4_v_q || push_ready_i;
  assign in_ready_o = en;

  assign lox_d = add_r(cfg_i.west_edge, cfg_i.radius, 1'b0);
  assign hix_d = add_r(cfg_i.east_edge, cfg_i.radius, 1'b1);
  assign loy_d = add_r(cfg_i.south_edge, cfg_i.radius, 1'b0);
  assign hiy_d = add_r(cfg_i.north_edge, cfg_i.radius, 1'b1);

  assign spx_d = {hix1_q[LO_W-1], hix1_q} - {lox1_q[LO_W-1], lox1_q};
  assign spy_d = {hiy1_q[LO_W-1], hiy1_q} - {loy1_q[LO_W-1], loy1_q};

  assign prx_d = $signed({1'b0, fx2_q}) * spx2_q;
  assign pry_d = $signed({1'b0, fy2_q}) * spy2_q;

  // floor division by 2^16 is the upper slice of the product
  assign sumx = {{(SUM_W-LO_W){lox3_q[LO_W-1]}}, lox3_q}
              + {prx3_q[PROD_W-1], prx3_q[PROD_W-1:FRAC_W]};
  assign sumy = {{(SUM_W-LO_W){loy3_q[LO_W-1]}}, loy3_q}
              + {pry3_q[PROD_W-1], pry3_q[PROD_W-1:FRAC_W]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      act1_q        <= ncp_action_e'(action_i);
      fx1_q         <= frac_x_i;
      fy1_q         <= frac_y_i;
      lox1_q        <= lox_d;
      hix1_q        <= hix_d;
      loy1_q        <= loy_d;
      hiy1_q        <= hiy_d;
      act2_q        <= act1_q;
      fx2_q         <= fx1_q;
      fy2_q         <= fy1_q;
      lox2_q        <= lox1_q;
      loy2_q        <= loy1_q;
      spx2_q        <= spx_d;
      spy2_q        <= spy_d;
      act3_q        <= act2_q;
      lox3_q        <= lox2_q;
      loy3_q        <= loy2_q;
      prx3_q        <= prx_d;
      pry3_q        <= pry_d;
      item_q.action <= act3_q;
      item_q.x      <= sat(sumx);
      item_q.y      <= sat(sumy);
    end
  end

  assign push_valid_o = s4_v_q;
  assign push_item_o  = item_q;

endmodule

[rtl/ncp_fifo.sv]
// Short queue of scaled candidates between the front end and the checker.
// Depends on ncp_pkg.
module ncp_fifo import ncp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  ncp_item_t push_item_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output ncp_item_t pop_item_o
);

  localparam int unsigned PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  ncp_item_t          buf_q [Q_DEPTH];
  logic [PTR_W-1:0]   wptr_q, rptr_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               push, pop;

  assign push_ready_o = cnt_q != CNT_W'(Q_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = buf_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + PTR_W'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= push_item_i;
    end
  end

endmodule

[rtl/ncp_back.sv]
// Checker: classifies each candidate, scans the centre store for overlap,
// keeps placement counters and holds the result register.
// Depends on ncp_pkg, ncp_ram and assert_macros.svh.
`include "assert_macros.svh"

module ncp_back import ncp_pkg::*; #(
  parameter int unsigned MAX_CIRCLES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ncp_cfg_t    cfg_i,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  input  ncp_item_t   q_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output ncp_result_t out_o
);

  localparam int unsigned AW    = $clog2(MAX_CIRCLES);
  localparam int unsigned PW    = $clog2(MAX_CIRCLES + 1);
  localparam int unsigned CW    = $clog2(2 * MAX_CIRCLES * MAX_CIRCLES + 1);
  localparam int unsigned CMPW  = (PW > COUNT_W) ? PW : COUNT_W;
  localparam int unsigned LIM_W = 2 * (RADIUS_W + 1);
  localparam int unsigned SQ_W  = 2 * COORD_W;

  ncp_back_state_e state_q, state_d;
  ncp_item_t       cur_q, cur_d;
  logic [PW-1:0]   placed_q, placed_d, issue_q, issue_d, placed_inc;
  logic [CW-1:0]   attempt_q, attempt_d, att_next;
  logic            failed_q, failed_d;
  logic            hit_q, hit_d, struggle_q, struggle_d;
  logic            rd_v_q, rd_v_d, ab_v_q, sq_v_q;

  logic [PW-1:0]    n_q;
  logic [CW-1:0]    warn_q, fail_q;
  logic [LIM_W-1:0] lim_q;
  logic [CMPW-1:0]  cc_ext;

  logic [COORD_W-1:0] rx, ry, absx_q, absy_q;
  logic [COORD_W:0]   dx, dy, negx, negy;
  logic [SQ_W-1:0]    sqx_q, sqy_q;
  logic [SQ_W:0]      sum_sq;

  logic            ram_we, pop, out_load;
  ncp_result_t     res, out_q;
  logic            out_valid_q;
  logic [AW+SLOT_W-1:0] slot_ext;

  assign cc_ext     = CMPW'(cfg_i.circle_count);
  assign placed_inc = placed_q + PW'(1);
  assign att_next   = (attempt_q < fail_q) ? attempt_q + CW'(1) : attempt_q;
  assign slot_ext   = {{SLOT_W{1'b0}}, placed_q[AW-1:0]};

  ncp_ram #(.WIDTH(COORD_W), .DEPTH(MAX_CIRCLES)) u_ram_x (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (placed_q[AW-1:0]),
    .wdata_i (cur_q.x),
    .raddr_i (issue_q[AW-1:0]),
    .rdata_o (rx)
  );

  ncp_ram #(.WIDTH(COORD_W), .DEPTH(MAX_CIRCLES)) u_ram_y (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (placed_q[AW-1:0]),
    .wdata_i (cur_q.y),
    .raddr_i (issue_q[AW-1:0]),
    .rdata_o (ry)
  );

  assign dx     = {rx[COORD_W-1], rx} - {cur_q.x[COORD_W-1], cur_q.x};
  assign dy     = {ry[COORD_W-1], ry} - {cur_q.y[COORD_W-1], cur_q.y};
  assign negx   = -dx;
  assign negy   = -dy;
  assign sum_sq = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    placed_d   = placed_q;
    attempt_d  = attempt_q;
    failed_d   = failed_q;
    issue_d    = issue_q;
    hit_d      = hit_q;
    struggle_d = struggle_q;
    rd_v_d     = 1'b0;
    ram_we     = 1'b0;
    pop        = 1'b0;
    out_load   = 1'b0;
    res        = '0;

    if (sq_v_q && (sum_sq < {{(SQ_W+1-LIM_W){1'b0}}, lim_q})) begin
      hit_d = 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        pop = !out_valid_q || out_ready_i;
        if (pop && q_valid_i) begin
          cur_d   = q_item_i;
          state_d = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        state_d      = ST_IDLE;
        out_load     = 1'b1;
        res.center_x = cur_q.x;
        res.center_y = cur_q.y;
        if (cur_q.action == ACT_RESTART) begin
          placed_d  = '0;
          attempt_d = '0;
          failed_d  = 1'b0;
          res       = '0;
        end else if (failed_q || (placed_q >= n_q)) begin
          res.complete   = placed_q >= n_q;
          res.struggling = attempt_q >= warn_q;
          res.gave_up    = failed_q;
        end else if (placed_q == '0) begin
          // first centre goes in unchecked
          ram_we       = 1'b1;
          placed_d     = placed_inc;
          attempt_d    = '0;
          res.accepted = 1'b1;
          res.slot     = slot_ext[SLOT_W-1:0];
          res.complete = placed_inc >= n_q;
        end else begin
          attempt_d  = att_next;
          struggle_d = att_next >= warn_q;
          if (att_next >= fail_q) begin
            failed_d       = 1'b1;
            res.struggling = att_next >= warn_q;
            res.gave_up    = 1'b1;
          end else begin
            out_load = 1'b0;
            issue_d  = '0;
            hit_d    = 1'b0;
            state_d  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_v_d = issue_q != placed_q;
        if (rd_v_d) begin
          issue_d = issue_q + PW'(1);
        end else if (!rd_v_q && !ab_v_q && !sq_v_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_d        = ST_IDLE;
        out_load       = 1'b1;
        res.center_x   = cur_q.x;
        res.center_y   = cur_q.y;
        res.struggling = struggle_q;
        res.complete   = placed_q >= n_q;
        if (!hit_q) begin
          ram_we       = 1'b1;
          placed_d     = placed_inc;
          attempt_d    = '0;
          res.accepted = 1'b1;
          res.slot     = slot_ext[SLOT_W-1:0];
          res.complete = placed_inc >= n_q;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      placed_q    <= '0;
      attempt_q   <= '0;
      failed_q    <= 1'b0;
      rd_v_q      <= 1'b0;
      ab_v_q      <= 1'b0;
      sq_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      placed_q    <= placed_d;
      attempt_q   <= attempt_d;
      failed_q    <= failed_d;
      rd_v_q      <= rd_v_d;
      ab_v_q      <= rd_v_q;
      sq_v_q      <= ab_v_q;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    issue_q    <= issue_d;
    hit_q      <= hit_d;
    struggle_q <= struggle_d;
    absx_q     <= dx[COORD_W] ? negx[COORD_W-1:0] : dx[COORD_W-1:0];
    absy_q     <= dy[COORD_W] ? negy[COORD_W-1:0] : dy[COORD_W-1:0];
    sqx_q      <= SQ_W'(absx_q) * SQ_W'(absx_q);
    sqy_q      <= SQ_W'(absy_q) * SQ_W'(absy_q);
    if (cc_ext == '0) begin
      n_q <= PW'(1);
    end else if (cc_ext > CMPW'(MAX_CIRCLES)) begin
      n_q <= PW'(MAX_CIRCLES);
    end else begin
      n_q <= PW'(cc_ext);
    end
    warn_q <= CW'(n_q) * CW'(n_q);
    fail_q <= {warn_q[CW-2:0], 1'b0};
    lim_q  <= LIM_W'({cfg_i.radius, 1'b0}) * LIM_W'({cfg_i.radius, 1'b0});
    if (out_load) begin
      out_q <= res;
    end
  end

  assign q_ready_o   = pop;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `ASSERT_IMPL(a_out_free, clk_i, rst_ni, out_load && out_valid_q, out_ready_i, "result overwritten")
  `ASSERT_IMPL(a_store_room, clk_i, rst_ni, ram_we, placed_q < n_q, "store write beyond count")
  `ASSERT_IMPL(a_fail_src, clk_i, rst_ni, $rose(failed_q), $past(state_q) == ST_CLASSIFY, "bad fail")
  `ASSERT_IMPL(a_scan_drained, clk_i, rst_ni, state_q == ST_FINISH, !rd_v_q && !ab_v_q && !sq_v_q, "scan not drained")

endmodule

[rtl/nonoverlap_circle_placer.sv]
// Top level of the circle placer: configuration registers, scaling front
// end, candidate queue and overlap checker. Depends on ncp_pkg, ncp_front,
// ncp_fifo and ncp_back.
//
// channel | handshake                 | payload
// cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
// in      | in_valid_i / in_ready_o   | action_i, frac_x_i, frac_y_i
// out     | out_valid_o / out_ready_i | accepted_o .. gave_up_o
//
// Scaling is pipelined; the checker then classifies each item, and an offer
// that reaches the overlap scan is also compared with every stored centre.
// The scan reads one stored centre a cycle.
// Reset clears control state; the centre store is only read where written.
// A stalled output holds the result and stops the checker; input keeps
// flowing until the 4-entry queue and the scaler are full.
module nonoverlap_circle_placer import ncp_pkg::*; #(
  parameter int unsigned MAX_CIRCLES = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [COORD_W-1:0]        cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      action_i,
  input  logic [FRAC_W-1:0]         frac_x_i,
  input  logic [FRAC_W-1:0]         frac_y_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      accepted_o,
  output logic signed [COORD_W-1:0] center_x_o,
  output logic signed [COORD_W-1:0] center_y_o,
  output logic [SLOT_W-1:0]         slot_o,
  output logic                      complete_o,
  output logic                      struggling_o,
  output logic                      gave_up_o
);

  ncp_cfg_t    cfg_q;
  logic        push_valid, push_ready, pop_valid, pop_ready;
  ncp_item_t   push_item, pop_item;
  ncp_result_t result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.circle_count <= COUNT_W'(1);
      cfg_q.radius       <= RADIUS_W'(1);
      cfg_q.west_edge    <= '0;
      cfg_q.east_edge    <= COORD_W'(1000);
      cfg_q.south_edge   <= '0;
      cfg_q.north_edge   <= COORD_W'(1000);
    end else if (cfg_valid_i) begin
      unique case (ncp_reg_e'(cfg_index_i))
        REG_CIRCLE_COUNT: cfg_q.circle_count <= cfg_data_i[COUNT_W-1:0];
        REG_RADIUS:       cfg_q.radius       <= cfg_data_i[RADIUS_W-1:0];
        REG_WEST_EDGE:    cfg_q.west_edge    <= cfg_data_i;
        REG_EAST_EDGE:    cfg_q.east_edge    <= cfg_data_i;
        REG_SOUTH_EDGE:   cfg_q.south_edge   <= cfg_data_i;
        REG_NORTH_EDGE:   cfg_q.north_edge   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  ncp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .frac_x_i     (frac_x_i),
    .frac_y_i     (frac_y_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  ncp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  ncp_back #(.MAX_CIRCLES(MAX_CIRCLES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (pop_valid),
    .q_ready_o   (pop_ready),
    .q_item_i    (pop_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (result)
  );

  assign accepted_o   = result.accepted;
  assign center_x_o   = result.center_x;
  assign center_y_o   = result.center_y;
  assign slot_o       = result.slot;
  assign complete_o   = result.complete;
  assign struggling_o = result.struggling;
  assign gave_up_o    = result.gave_up;

endmodule
